// File: sv/glc_pkg.sv
`default_nettype none

package glc_pkg;

  typedef logic [14:0] ofs_t;

  localparam ofs_t CAP_LIMIT = 15'h7FFF;
  localparam ofs_t CAP_RESET = 15'd200;

  // configuration register indexes
  localparam logic [1:0] CFG_GROWTH_MODE = 2'd0;
  localparam logic [1:0] CFG_GROWTH_STEP = 2'd1;
  localparam logic [1:0] CFG_INIT_CAP    = 2'd2;

  // growth modes
  localparam logic [1:0] GROW_FIXED = 2'd0;
  localparam logic [1:0] GROW_ADD   = 2'd1;
  localparam logic [1:0] GROW_MUL   = 2'd2;

  // opcodes on the input channel
  localparam logic [2:0] OP_APPEND  = 3'd0;
  localparam logic [2:0] OP_READ    = 3'd1;
  localparam logic [2:0] OP_MARK    = 3'd2;
  localparam logic [2:0] OP_RETRACT = 3'd3;
  localparam logic [2:0] OP_TO_MARK = 3'd4;
  localparam logic [2:0] OP_CLEAR   = 3'd5;
  localparam logic [2:0] OP_PACK    = 3'd6;

  // floor(x/100) for x < 2^23: q0 = (x*K) >> 23 is q or q-1
  localparam logic [16:0] RECIP_K   = 17'd83886;
  localparam logic [23:0] DIV_BASE  = 24'd100;

  typedef enum logic [2:0] {
    CMD_APPEND,
    CMD_READ,
    CMD_MARK,
    CMD_RETRACT,
    CMD_TO_MARK,
    CMD_CLEAR,
    CMD_PACK,
    CMD_NOP
  } cmd_kind_t;

  typedef struct packed {
    cmd_kind_t   kind;
    logic [7:0]  symbol;
    ofs_t        mark_pos;
  } cmd_t;

  typedef struct packed {
    logic push;
    cmd_t cmd;
  } q_wr_t;

  typedef struct packed {
    logic valid;
    cmd_t cmd;
  } q_rd_t;

  typedef struct packed {
    logic ok;
    logic rd_hit;
    logic eob;
    logic grew;
    logic full;
    logic empty;
    ofs_t size;
    ofs_t cap;
    ofs_t mark;
    ofs_t rd;
  } res_t;

  typedef enum logic [1:0] {
    EX_RUN,
    EX_MUL,
    EX_FIX
  } ex_state_t;

endpackage

`default_nettype wire

// File: sv/glc_front.sv
`default_nettype none

module glc_front
  import glc_pkg::*;
(
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [2:0]  in_tuser,
  input  wire logic [23:0] in_tdata,
  input  wire logic        q_full,
  output q_wr_t            q_wr
);

  cmd_kind_t kind;

  always_comb begin
    unique case (in_tuser)
      OP_APPEND:  kind = CMD_APPEND;
      OP_READ:    kind = CMD_READ;
      OP_MARK:    kind = CMD_MARK;
      OP_RETRACT: kind = CMD_RETRACT;
      OP_TO_MARK: kind = CMD_TO_MARK;
      OP_CLEAR:   kind = CMD_CLEAR;
      OP_PACK:    kind = CMD_PACK;
      default:    kind = CMD_NOP;
    endcase
  end

  assign in_tready       = !q_full;
  assign q_wr.push       = in_tvalid && !q_full;
  assign q_wr.cmd.kind   = kind;
  assign q_wr.cmd.symbol = in_tdata[7:0];
  assign q_wr.cmd.mark_pos = in_tdata[22:8];

endmodule

`default_nettype wire

// File: sv/glc_fifo.sv
`default_nettype none

module glc_fifo
  import glc_pkg::*;
(
  input  wire logic  clk,
  input  wire logic  rst_n,
  input  wire q_wr_t q_wr,
  output logic       q_full,
  output q_rd_t      q_rd,
  input  wire logic  q_pop
);

  cmd_t       ent_r [2];
  logic       wp_r, wp_nxt;
  logic       rp_r, rp_nxt;
  logic [1:0] cnt_r, cnt_nxt;

  assign q_full     = (cnt_r == 2'd2);
  assign q_rd.valid = (cnt_r != 2'd0);
  assign q_rd.cmd   = ent_r[rp_r];

  always_comb begin
    wp_nxt  = wp_r;
    rp_nxt  = rp_r;
    cnt_nxt = cnt_r;
    if (q_wr.push) begin
      wp_nxt = !wp_r;
    end
    if (q_pop) begin
      rp_nxt = !rp_r;
    end
    if (q_wr.push && !q_pop) begin
      cnt_nxt = cnt_r + 2'd1;
    end else if (!q_wr.push && q_pop) begin
      cnt_nxt = cnt_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (q_wr.push) begin
      ent_r[wp_r] <= q_wr.cmd;
    end
  end

endmodule

`default_nettype wire

// File: sv/glc_exec.sv
`default_nettype none

module glc_exec
  import glc_pkg::*;
#(
  parameter int STORE_DEPTH = 32768
)
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        cfg_we,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [14:0] cfg_wdata,
  input  wire q_rd_t       q_rd,
  output logic             q_pop,
  output logic             res_valid,
  input  wire logic        res_ready,
  output res_t             res,
  output logic [7:0]       res_data
);

  localparam int AW = $clog2(STORE_DEPTH);

  logic [1:0]  mode_r;
  logic [7:0]  step_r;

  ofs_t        wo_r, wo_nxt;
  ofs_t        ro_r, ro_nxt;
  ofs_t        mk_r, mk_nxt;
  ofs_t        cap_r, cap_nxt;
  logic        eob_r, eob_nxt;
  logic        grew_r, grew_nxt;
  ex_state_t   state_r, state_nxt;
  logic        ov_r, ov_nxt;
  res_t        res_r, res_nxt;

  logic [7:0]  sym_r, sym_nxt;
  logic [22:0] prod_r, prod_nxt;
  logic [16:0] qa_r, qa_nxt;

  logic [7:0]  mem [STORE_DEPTH];
  logic [7:0]  mem_q_r;
  logic        mem_we, mem_re;
  logic [7:0]  mem_wd;

  logic        slot_free;
  logic        take;
  logic [15:0] add_sum;
  logic        add_ok;
  logic [39:0] recip_prod;
  logic [23:0] rem;
  logic [16:0] q_fix;
  logic [17:0] mul_sum;
  ofs_t        mul_nc;
  logic        ok;
  logic        rd_hit;

  assign slot_free = !ov_r || res_ready;
  assign take      = (state_r == EX_RUN) && q_rd.valid && slot_free;
  assign q_pop     = take;

  // additive growth: one add and compare
  assign add_sum = {1'b0, cap_r} + {8'd0, step_r};
  assign add_ok  = (add_sum < {1'b0, CAP_LIMIT}) && (add_sum[14:0] > wo_r);

  // multiplicative growth: (limit-cap)*step, then /100 by reciprocal
  assign prod_nxt   = 23'(CAP_LIMIT - cap_r) * 23'(step_r);
  assign recip_prod = 40'(prod_r) * 40'(RECIP_K);
  assign qa_nxt     = recip_prod[39:23];
  assign rem        = 24'(prod_r) - 24'(qa_r) * DIV_BASE;
  assign q_fix      = qa_r + 17'((rem >= DIV_BASE) ? 1 : 0);
  assign mul_sum    = {3'd0, cap_r} + {1'b0, q_fix};

  always_comb begin
    if (q_fix == 17'd0) begin
      mul_nc = CAP_LIMIT;
    end else if (mul_sum > {3'd0, CAP_LIMIT}) begin
      mul_nc = CAP_LIMIT;
    end else begin
      mul_nc = mul_sum[14:0];
    end
  end

  always_comb begin
    wo_nxt    = wo_r;
    ro_nxt    = ro_r;
    mk_nxt    = mk_r;
    cap_nxt   = cap_r;
    eob_nxt   = eob_r;
    grew_nxt  = grew_r;
    state_nxt = state_r;
    sym_nxt   = sym_r;
    ov_nxt    = ov_r && !res_ready;
    ok        = 1'b0;
    rd_hit    = 1'b0;
    mem_we    = 1'b0;
    mem_re    = 1'b0;
    mem_wd    = q_rd.cmd.symbol;

    unique case (state_r)
      EX_RUN: begin
        if (take) begin
          ov_nxt = 1'b1;
          unique case (q_rd.cmd.kind)
            CMD_APPEND: begin
              grew_nxt = 1'b0;
              if (wo_r < cap_r) begin
                mem_we = 1'b1;
                wo_nxt = wo_r + 15'd1;
                ok     = 1'b1;
              end else if (mode_r == GROW_ADD && step_r != 8'd0 && add_ok) begin
                cap_nxt  = add_sum[14:0];
                mem_we   = 1'b1;
                wo_nxt   = wo_r + 15'd1;
                grew_nxt = 1'b1;
                ok       = 1'b1;
              end else if (mode_r == GROW_MUL && step_r != 8'd0 &&
                           cap_r != CAP_LIMIT) begin
                // result comes out of the growth sequence
                ov_nxt    = 1'b0;
                sym_nxt   = q_rd.cmd.symbol;
                state_nxt = EX_MUL;
              end
            end
            CMD_READ: begin
              if (ro_r == wo_r) begin
                eob_nxt = 1'b1;
              end else begin
                eob_nxt = 1'b0;
                mem_re  = 1'b1;
                rd_hit  = 1'b1;
                ro_nxt  = ro_r + 15'd1;
                ok      = 1'b1;
              end
            end
            CMD_MARK: begin
              if (q_rd.cmd.mark_pos <= wo_r) begin
                mk_nxt = q_rd.cmd.mark_pos;
                ok     = 1'b1;
              end
            end
            CMD_RETRACT: begin
              if (ro_r != 15'd0) begin
                ro_nxt = ro_r - 15'd1;
                ok     = 1'b1;
              end
            end
            CMD_TO_MARK: begin
              ro_nxt = mk_r;
              ok     = 1'b1;
            end
            CMD_CLEAR: begin
              wo_nxt   = 15'd0;
              ro_nxt   = 15'd0;
              mk_nxt   = 15'd0;
              eob_nxt  = 1'b0;
              grew_nxt = 1'b0;
              ok       = 1'b1;
            end
            CMD_PACK: begin
              grew_nxt = 1'b0;
              if (cap_r != CAP_LIMIT && wo_r != CAP_LIMIT) begin
                cap_nxt = wo_r + 15'd1;
                ok      = 1'b1;
              end
            end
            default: begin
            end
          endcase
        end
      end
      EX_MUL: begin
        state_nxt = EX_FIX;
      end
      EX_FIX: begin
        // output slot is known free: nothing was emitted since the pop
        ov_nxt    = 1'b1;
        state_nxt = EX_RUN;
        mem_wd    = sym_r;
        if (mul_nc > wo_r) begin
          cap_nxt  = mul_nc;
          mem_we   = 1'b1;
          wo_nxt   = wo_r + 15'd1;
          grew_nxt = 1'b1;
          ok       = 1'b1;
        end
      end
      default: begin
        state_nxt = EX_RUN;
      end
    endcase

    res_nxt.ok     = ok;
    res_nxt.rd_hit = rd_hit;
    res_nxt.eob    = eob_nxt;
    res_nxt.grew   = grew_nxt;
    res_nxt.full   = (wo_nxt == cap_nxt);
    res_nxt.empty  = (wo_nxt == 15'd0);
    res_nxt.size   = wo_nxt;
    res_nxt.cap    = cap_nxt;
    res_nxt.mark   = mk_nxt;
    res_nxt.rd     = ro_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r  <= GROW_FIXED;
      step_r  <= 8'd0;
      wo_r    <= 15'd0;
      ro_r    <= 15'd0;
      mk_r    <= 15'd0;
      cap_r   <= CAP_RESET;
      eob_r   <= 1'b0;
      grew_r  <= 1'b0;
      state_r <= EX_RUN;
      ov_r    <= 1'b0;
    end else begin
      // initial capacity only matters at reset, which restores its default
      if (cfg_we && cfg_index == CFG_GROWTH_MODE) begin
        mode_r <= cfg_wdata[1:0];
      end
      if (cfg_we && cfg_index == CFG_GROWTH_STEP) begin
        step_r <= cfg_wdata[7:0];
      end
      wo_r    <= wo_nxt;
      ro_r    <= ro_nxt;
      mk_r    <= mk_nxt;
      cap_r   <= cap_nxt;
      eob_r   <= eob_nxt;
      grew_r  <= grew_nxt;
      state_r <= state_nxt;
      ov_r    <= ov_nxt;
    end
  end

  always_ff @(posedge clk) begin
    sym_r <= sym_nxt;
    qa_r  <= qa_nxt;
    if (take) begin
      prod_r <= prod_nxt;
    end
    if (ov_nxt && !(ov_r && !res_ready)) begin
      res_r <= res_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[wo_r[AW-1:0]] <= mem_wd;
    end
    if (mem_re) begin
      mem_q_r <= mem[ro_r[AW-1:0]];
    end
  end

  assign res_valid = ov_r;
  assign res       = res_r;
  assign res_data  = res_r.rd_hit ? mem_q_r : 8'h00;

endmodule

`default_nettype wire

// File: sv/growable_lexer_char_buffer.sv
`default_nettype none

// Channel   Dir  Handshake          Payload
// in_       in   tvalid / tready    tuser: opcode; tdata: symbol, mark_position
// out_      out  tvalid / tready    tdata: ok .. read_now (one result per item)
// cfg_      in   we (no wait)       index, wdata
//
// Each item is held in the queue, then the execute stage registers its result.
// An append that grows capacity in multiplicative mode holds the execute stage
// for its steps: step product, reciprocal multiply, correct and commit.
// Reset (sync, rst_n low) clears offsets and flags, capacity becomes 200; the
// byte store has no clearing pass and holds garbage until written.
// A stalled out_tready holds the result; the two-entry queue keeps taking
// items until full, then in_tready drops.

module growable_lexer_char_buffer
  import glc_pkg::*;
#(
  parameter int STORE_DEPTH = 32768
)
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  // configuration
  input  wire logic        cfg_we,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [14:0] cfg_wdata,
  // input stream
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [2:0]  in_tuser,   // [2:0] opcode
  input  wire logic [23:0] in_tdata,   // [7:0] symbol, [22:8] mark_position, [23] zero
  // result stream
  output logic             out_tvalid,
  input  wire logic        out_tready,
  // [0] ok, [8:1] data, [9] end_of_buffer, [10] grew, [11] full_res,
  // [12] empty_res, [27:13] size_now, [42:28] capacity_now,
  // [57:43] mark_now, [72:58] read_now, [79:73] zero
  output logic [79:0]      out_tdata
);

  q_wr_t      q_wr;
  q_rd_t      q_rd;
  logic       q_full;
  logic       q_pop;
  res_t       res;
  logic [7:0] res_data;

  // front: handshake and opcode decode
  glc_front u_front (
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tuser  (in_tuser),
    .in_tdata  (in_tdata),
    .q_full    (q_full),
    .q_wr      (q_wr)
  );

  // decouples front from the execute stage
  glc_fifo u_fifo (
    .clk    (clk),
    .rst_n  (rst_n),
    .q_wr   (q_wr),
    .q_full (q_full),
    .q_rd   (q_rd),
    .q_pop  (q_pop)
  );

  // back: offsets, byte store, growth unit, result register
  glc_exec #(
    .STORE_DEPTH (STORE_DEPTH)
  ) u_exec (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .q_rd      (q_rd),
    .q_pop     (q_pop),
    .res_valid (out_tvalid),
    .res_ready (out_tready),
    .res       (res),
    .res_data  (res_data)
  );

  assign out_tdata = {7'd0, res.rd, res.mark, res.cap, res.size,
                      res.empty, res.full, res.grew, res.eob, res_data, res.ok};

endmodule

`default_nettype wire
